[sv/tce_pkg.sv]
package tce_pkg;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  seg_flags;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [10:0] pay_len;
  } in_word_t;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  out_flags;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic [15:0] out_window;
    logic [10:0] out_len;
    logic [3:0]  conn_state;
    logic [10:0] app_limit;
    logic        fin_to_app;
    logic        error;
    logic        last;
  } out_word_t;

  typedef enum logic [2:0] {
    EV_OPEN_ACTIVE  = 3'd0,
    EV_OPEN_PASSIVE = 3'd1,
    EV_APP_DATA     = 3'd2,
    EV_SEGMENT      = 3'd3,
    EV_CLOSE        = 3'd4
  } event_t;

  localparam logic [3:0] ST_ESTABLISHED = 4'd0;
  localparam logic [3:0] ST_LISTEN      = 4'd1;
  localparam logic [3:0] ST_SYN_OUT     = 4'd2;
  localparam logic [3:0] ST_SYN_RCVD    = 4'd3;
  localparam logic [3:0] ST_FIN_WAIT_1  = 4'd4;
  localparam logic [3:0] ST_FIN_WAIT_2  = 4'd5;
  localparam logic [3:0] ST_CLOSE_WAIT  = 4'd6;
  localparam logic [3:0] ST_LAST_ACK    = 4'd7;
  localparam logic [3:0] ST_CLOSED      = 4'd9;

  localparam logic [7:0] FL_FIN = 8'h01;
  localparam logic [7:0] FL_SYN = 8'h02;
  localparam logic [7:0] FL_ACK = 8'h10;

  localparam logic [2:0] REG_ISN  = 3'd0;
  localparam logic [2:0] REG_WIN  = 3'd1;
  localparam logic [2:0] REG_MSS  = 3'd2;
  localparam logic [2:0] REG_SST  = 3'd3;
  localparam logic [2:0] REG_CAP  = 3'd4;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[sv/tce_queue.sv]
module tce_queue
  import tce_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  in_word_t  push_data,
  input  logic      pop,
  output in_word_t  pop_data,
  output q_status_t status
);
  in_word_t   slots [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign pop_data     = slots[rd_ptr];
  assign status.full  = (count == 2'(QDEPTH));
  assign status.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

[sv/tce_divider.sv]
module tce_divider
  import tce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [21:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [21:0] quotient
);
  // restoring divide, one quotient bit per cycle
  logic [21:0] q;
  logic [32:0] rem;
  logic [4:0]  cnt;
  logic [32:0] trial;

  assign trial    = {rem[31:0], q[21]} - {1'b0, divisor};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 5'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'd21;
      q    <= dividend;
      rem  <= 33'd0;
    end else if (busy) begin
      if (trial[32]) begin
        rem <= {rem[31:0], q[21]};
        q   <= {q[20:0], 1'b0};
      end else begin
        rem <= trial;
        q   <= {q[20:0], 1'b1};
      end
      if (cnt == 5'd0) busy <= 1'b0;
      else cnt <= cnt - 5'd1;
    end
  end
endmodule

[sv/tce_engine.sv]
module tce_engine
  import tce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  q_status_t   q_stat,
  input  in_word_t    q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_WIN  = 5'b00100,
    S_OUT0 = 5'b01000,
    S_OUT1 = 5'b10000
  } eng_state_t;

  eng_state_t state;

  logic [31:0] isn;
  logic [15:0] adv_win;
  logic [10:0] mss;
  logic [15:0] ss_lim;
  logic [15:0] win_cap;

  logic [3:0]  phase;
  logic [31:0] peer_seq, peer_ack, next_send_seq, last_ack_sent;
  logic [10:0] peer_len, last_sent_len;
  logic [31:0] cwnd;
  logic [15:0] send_window, rem_window;
  logic        ack_pending;

  logic [1:0]  res_count;
  logic [7:0]  r_flags [2];
  logic [31:0] r_seq [2];
  logic [31:0] r_ack [2];
  logic [10:0] r_len [2];
  logic        err_f, fin_f, data_acked;

  logic        div_start, div_busy;
  logic [21:0] div_q;
  logic [21:0] mss_sq;

  assign mss_sq = 22'(mss) * 22'(mss);

  tce_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(mss_sq),
    .divisor(cwnd), .busy(div_busy), .quotient(div_q)
  );

  logic [10:0] app_lim;
  assign app_lim = (16'(mss) < rem_window) ? mss : rem_window[10:0];

  logic [10:0] ctl_n, ctl_len;
  assign ctl_n   = (q_data.pay_len < mss) ? q_data.pay_len : mss;
  assign ctl_len = (ctl_n == 11'd0) ? 11'd1 : ctl_n;

  logic [10:0] dat_n;
  assign dat_n = (q_data.pay_len < app_lim) ? q_data.pay_len : app_lim;

  // window math
  logic [32:0] cw_sum;
  logic [31:0] cw_new;
  logic [15:0] nw;
  logic signed [19:0] r_sum;
  logic [31:0] inc;

  always_comb begin
    if (cwnd < 32'(ss_lim)) inc = 32'(mss);
    else if (cwnd == 32'd0) inc = 32'(mss_sq);
    else inc = 32'(div_q);
    cw_sum = data_acked ? (33'(cwnd) + 33'(inc)) : 33'(cwnd);
    cw_new = cw_sum[32] ? 32'hFFFF_FFFF : cw_sum[31:0];
    nw     = (cw_new < 32'(win_cap)) ? cw_new[15:0] : win_cap;
    r_sum  = 20'(rem_window) + (data_acked ? 20'(last_sent_len) : 20'd0)
           + 20'(nw) - 20'(send_window);
  end

  logic sel;
  assign sel = (state == S_OUT1);

  always_comb begin
    out_word = '0;
    out_word.send_valid = (res_count != 2'd0);
    if (res_count != 2'd0) begin
      out_word.out_flags  = r_flags[sel];
      out_word.out_seq    = r_seq[sel];
      out_word.out_ack    = r_ack[sel];
      out_word.out_window = adv_win;
      out_word.out_len    = r_len[sel];
    end
    out_word.conn_state = phase;
    out_word.app_limit  = app_lim;
    out_word.fin_to_app = fin_f;
    out_word.error      = err_f;
    out_word.last       = sel || (res_count != 2'd2);
  end

  assign out_valid = (state == S_OUT0) || (state == S_OUT1);
  assign q_pop     = (state == S_IDLE) && !q_stat.empty;
  assign div_start = q_pop && (q_data.mode == EV_SEGMENT) && (phase == ST_ESTABLISHED)
                     && ack_pending && (q_data.seg_flags == FL_ACK);

  always_ff @(posedge clk) begin
    if (rst) begin
      isn <= 32'd1; adv_win <= 16'd3072; mss <= 11'd536;
      ss_lim <= 16'd2144; win_cap <= 16'd3072;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ISN: isn     <= cfg_data;
        REG_WIN: adv_win <= cfg_data[15:0];
        REG_MSS: mss     <= cfg_data[10:0];
        REG_SST: ss_lim  <= cfg_data[15:0];
        REG_CAP: win_cap <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= ST_CLOSED;
      peer_seq <= '0; peer_ack <= '0; peer_len <= '0;
      next_send_seq <= '0; last_ack_sent <= '0; last_sent_len <= '0;
      // windows start at the reset MSS
      cwnd <= 32'd536; send_window <= 16'd536; rem_window <= 16'd536;
      ack_pending <= 1'b0;
      res_count <= '0; err_f <= 1'b0; fin_f <= 1'b0; data_acked <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (q_pop) begin
          res_count <= 2'd0; err_f <= 1'b0; fin_f <= 1'b0; data_acked <= 1'b0;
          state <= S_OUT0;
          if (q_data.mode == EV_OPEN_ACTIVE && phase == ST_CLOSED) begin
            peer_seq <= '0; peer_ack <= '0; peer_len <= '0; next_send_seq <= '0;
            cwnd <= 32'(mss); send_window <= 16'(mss); rem_window <= 16'(mss);
            ack_pending <= 1'b0;
            r_flags[0] <= FL_SYN; r_seq[0] <= isn; r_ack[0] <= '0; r_len[0] <= '0;
            res_count <= 2'd1;
            last_ack_sent <= '0; last_sent_len <= 11'd1;
            phase <= ST_SYN_OUT;
          end else if (q_data.mode == EV_OPEN_PASSIVE && phase == ST_CLOSED) begin
            peer_seq <= '0; peer_ack <= '0; peer_len <= '0; next_send_seq <= '0;
            last_ack_sent <= '0; last_sent_len <= '0;
            cwnd <= 32'(mss); send_window <= 16'(mss); rem_window <= 16'(mss);
            ack_pending <= 1'b0;
            phase <= ST_LISTEN;
          end else if (q_data.mode == EV_APP_DATA && phase == ST_ESTABLISHED
                       && !ack_pending) begin
            if (dat_n == 11'd0) begin
              err_f <= 1'b1; phase <= ST_CLOSED;
            end else begin
              r_flags[0] <= 8'd0; r_seq[0] <= next_send_seq;
              r_ack[0] <= last_ack_sent; r_len[0] <= dat_n;
              res_count <= 2'd1;
              last_sent_len <= dat_n;
              rem_window <= rem_window - 16'(dat_n);
              ack_pending <= 1'b1;
            end
          end else if (q_data.mode == EV_CLOSE && phase == ST_ESTABLISHED
                       && !ack_pending) begin
            r_flags[0] <= FL_FIN | FL_ACK; r_seq[0] <= peer_ack;
            r_ack[0] <= peer_seq + 32'd1; r_len[0] <= '0;
            res_count <= 2'd1;
            last_ack_sent <= peer_seq + 32'd1; last_sent_len <= 11'd1;
            phase <= ST_FIN_WAIT_1;
          end else if (q_data.mode == EV_SEGMENT && phase != ST_CLOSED) begin
            case (phase)
              ST_LISTEN:
                if (q_data.seg_flags == FL_SYN) begin
                  peer_seq <= q_data.seg_seq; peer_ack <= q_data.seg_ack;
                  peer_len <= ctl_len; next_send_seq <= isn;
                  r_flags[0] <= FL_SYN | FL_ACK; r_seq[0] <= isn;
                  r_ack[0] <= q_data.seg_seq + 32'd1; r_len[0] <= '0;
                  res_count <= 2'd1;
                  last_ack_sent <= q_data.seg_seq + 32'd1; last_sent_len <= 11'd1;
                  phase <= ST_SYN_RCVD;
                end else begin
                  err_f <= 1'b1; phase <= ST_CLOSED; ack_pending <= 1'b0;
                end
              ST_SYN_OUT, ST_FIN_WAIT_2:
                if ((phase == ST_SYN_OUT && q_data.seg_flags == (FL_SYN | FL_ACK)) ||
                    (phase == ST_FIN_WAIT_2 && q_data.seg_flags == (FL_FIN | FL_ACK))) begin
                  peer_seq <= q_data.seg_seq; peer_ack <= q_data.seg_ack;
                  peer_len <= ctl_len; next_send_seq <= q_data.seg_ack;
                  r_flags[0] <= FL_ACK; r_seq[0] <= q_data.seg_ack;
                  r_ack[0] <= q_data.seg_seq + 32'(ctl_len); r_len[0] <= '0;
                  res_count <= 2'd1;
                  last_ack_sent <= q_data.seg_seq + 32'(ctl_len);
                  last_sent_len <= 11'd1;
                  phase <= (phase == ST_SYN_OUT) ? ST_ESTABLISHED : ST_CLOSED;
                end else begin
                  err_f <= 1'b1; phase <= ST_CLOSED; ack_pending <= 1'b0;
                end
              ST_SYN_RCVD, ST_FIN_WAIT_1, ST_LAST_ACK:
                if (q_data.seg_flags == FL_ACK) begin
                  peer_seq <= q_data.seg_seq; peer_ack <= q_data.seg_ack;
                  peer_len <= ctl_len; next_send_seq <= q_data.seg_ack;
                  state <= S_WIN;
                  phase <= (phase == ST_SYN_RCVD) ? ST_ESTABLISHED :
                           (phase == ST_FIN_WAIT_1) ? ST_FIN_WAIT_2 : ST_CLOSED;
                end else begin
                  err_f <= 1'b1; phase <= ST_CLOSED; ack_pending <= 1'b0;
                end
              ST_ESTABLISHED:
                if (ack_pending) begin
                  if (q_data.seg_flags == FL_ACK) begin
                    peer_seq <= q_data.seg_seq; peer_ack <= q_data.seg_ack;
                    peer_len <= ctl_len; next_send_seq <= q_data.seg_ack;
                    data_acked <= 1'b1; ack_pending <= 1'b0;
                    state <= S_DIV;
                  end else begin
                    err_f <= 1'b1; phase <= ST_CLOSED; ack_pending <= 1'b0;
                  end
                end else if (q_data.seg_flags == (FL_FIN | FL_ACK)) begin
                  // reply uses the stored peer values, not this segment's
                  r_flags[0] <= FL_ACK; r_seq[0] <= next_send_seq;
                  r_ack[0] <= peer_seq + 32'(peer_len); r_len[0] <= '0;
                  r_flags[1] <= FL_FIN | FL_ACK; r_seq[1] <= peer_ack;
                  r_ack[1] <= peer_seq + 32'd1; r_len[1] <= '0;
                  res_count <= 2'd2; fin_f <= 1'b1;
                  last_ack_sent <= peer_seq + 32'd1; last_sent_len <= 11'd1;
                  phase <= ST_LAST_ACK;
                end else begin
                  peer_seq <= q_data.seg_seq; peer_ack <= q_data.seg_ack;
                  peer_len <= dat_n;
                  r_flags[0] <= FL_ACK; r_seq[0] <= next_send_seq;
                  r_ack[0] <= q_data.seg_seq + 32'(dat_n); r_len[0] <= '0;
                  res_count <= 2'd1;
                  last_ack_sent <= q_data.seg_seq + 32'(dat_n);
                  last_sent_len <= 11'd1;
                end
              default: begin
                err_f <= 1'b1; phase <= ST_CLOSED; ack_pending <= 1'b0;
              end
            endcase
          end
        end
        S_DIV: if (!div_busy) state <= S_WIN;
        S_WIN: begin
          cwnd <= cw_new;
          send_window <= nw;
          rem_window <= (r_sum < 0) ? 16'd0 : (r_sum > 20'sd65535) ? 16'hFFFF
                        : r_sum[15:0];
          state <= S_OUT0;
        end
        S_OUT0: if (!out_stall) state <= (res_count == 2'd2) ? S_OUT1 : S_IDLE;
        S_OUT1: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[sv/tce_front.sv]
module tce_front
  import tce_pkg::*;
(
  input  logic      in_valid,
  input  in_word_t  in_word,
  input  q_status_t q_stat,
  output logic      in_stall,
  output logic      push,
  output in_word_t  push_data
);
  // fold undefined modes onto an ignored code
  always_comb begin
    push_data = in_word;
    if (!(in_word.mode inside {EV_OPEN_ACTIVE, EV_OPEN_PASSIVE, EV_APP_DATA,
                               EV_SEGMENT, EV_CLOSE}))
      push_data.mode = 3'(EV_CLOSE) + 3'd1;
  end
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;
endmodule

[sv/tcp_connection_engine_top.sv]
// Flow: an accepted word is queued; the engine pops it in S_IDLE and gives results in S_OUT0,
//   passing S_WIN first for an ACK that only updates the window, and S_DIV then S_WIN for
//   an ACK of a data segment (22-step divide). The queue takes words while the engine is busy;
//   a two-result event adds S_OUT1, and output stalls hold S_OUT0 and S_OUT1.
// Reset (rst, synchronous): connection CLOSED, registers to defaults, queue empty.
module tcp_connection_engine_top
  import tce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  q_status_t q_stat;
  logic      push, pop;
  in_word_t  push_data, pop_data;

  // config is always taken; write only while no event is in flight
  assign cfg_ready = 1'b1;

  // front: classify and hand off to the queue
  tce_front u_front (
    .in_valid(in_valid), .in_word(in_word), .q_stat(q_stat),
    .in_stall(in_stall), .push(push), .push_data(push_data)
  );

  tce_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .pop(pop), .pop_data(pop_data), .status(q_stat)
  );

  // back: run the connection state machine and deliver results
  tce_engine u_engine (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .q_stat(q_stat), .q_data(pop_data), .q_pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );
endmodule

[sv/tce_checker.sv]
module tce_checker
  import tce_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word)) else $error("held word changed");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.send_valid |-> out_word.out_seq == 32'd0 && out_word.last)
    else $error("empty result not clean");
  a_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_word.last |=> out_valid && out_word.send_valid)
    else $error("second result missing");
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.error |-> out_word.conn_state == ST_CLOSED)
    else $error("error without close");
endmodule

bind tcp_connection_engine_top tce_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
);

[test/tcp_connection_engine_checker.sv]
module tcp_connection_engine_checker
  import tce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_word_t    in_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_word_t   out_word,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [31:0] isn;
  logic [15:0] adv_win;
  logic [10:0] mss;
  logic [15:0] ssthresh;
  logic [15:0] win_cap;

  // connection state
  logic [3:0]  phase;
  logic [31:0] peer_seq, peer_ack, peer_len;
  logic [31:0] snd_nxt, ack_sent, sent_len, cwnd;
  int unsigned swnd, rwnd;
  bit          ack_wait;

  // segments produced by the event being predicted
  logic [7:0]  tx_flags [2];
  logic [31:0] tx_seq [2];
  logic [31:0] tx_ack [2];
  logic [10:0] tx_len [2];
  int          tx_n;

  out_word_t   segments_due [$];

  function automatic void queue_tx(logic [7:0] f, logic [31:0] s, logic [31:0] a,
                                   logic [10:0] l);
    if (tx_n < 2) begin
      tx_flags[tx_n] = f;
      tx_seq[tx_n]   = s;
      tx_ack[tx_n]   = a;
      tx_len[tx_n]   = l;
      tx_n++;
    end
  endfunction

  function automatic logic [10:0] app_room();
    return (rwnd < 32'(mss)) ? rwnd[10:0] : mss;
  endfunction

  function automatic void restart_conn();
    peer_seq = '0; peer_ack = '0; peer_len = '0;
    snd_nxt = '0; ack_sent = '0; sent_len = '0;
    cwnd = 32'(mss); swnd = 32'(mss); rwnd = 32'(mss);
    ack_wait = 1'b0;
  endfunction

  function automatic void absorb_ctrl(logic [31:0] s, logic [31:0] a, logic [10:0] dl);
    logic [10:0] n;
    n = (dl < mss) ? dl : mss;
    peer_seq = s;
    peer_ack = a;
    peer_len = (n == 0) ? 32'd1 : 32'(n);
    snd_nxt  = a;
  endfunction

  function automatic void ack_peer();
    logic [31:0] a;
    a = peer_seq + peer_len;
    queue_tx(FL_ACK, snd_nxt, a, '0);
    ack_sent = a;
    sent_len = 32'd1;
  endfunction

  function automatic void fin_peer();
    logic [31:0] a;
    a = peer_seq + 32'd1;
    queue_tx(FL_FIN | FL_ACK, peer_ack, a, '0);
    ack_sent = a;
    sent_len = 32'd1;
  endfunction

  // cwnd growth on a data ACK, then re-derive the usable window
  function automatic void grow_window(bit data_acked);
    longint      inc, c, r;
    int unsigned nw, old;
    old = swnd;
    if (data_acked) begin
      if (cwnd < 32'(ssthresh)) inc = longint'(mss);
      else if (cwnd == 0) inc = longint'(mss) * mss;
      else inc = (longint'(mss) * mss) / longint'(cwnd);
      c = longint'(cwnd) + inc;
      cwnd = (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
    end
    nw = (cwnd < 32'(win_cap)) ? cwnd : 32'(win_cap);
    r = longint'(rwnd) + (data_acked ? longint'(sent_len) : 0) + longint'(nw) - longint'(old);
    if (r < 0) r = 0;
    if (r > 65535) r = 65535;
    rwnd = r[31:0];
    swnd = nw;
  endfunction

  function automatic void predict_event(in_word_t w);
    bit          err, fin_app;
    int          total;
    logic [10:0] lim, n;
    out_word_t   e;
    err = 1'b0;
    fin_app = 1'b0;
    tx_n = 0;
    if (w.mode == EV_OPEN_ACTIVE && phase == ST_CLOSED) begin
      restart_conn();
      queue_tx(FL_SYN, isn, '0, '0);
      ack_sent = '0;
      sent_len = 32'd1;
      phase = ST_SYN_OUT;
    end else if (w.mode == EV_OPEN_PASSIVE && phase == ST_CLOSED) begin
      restart_conn();
      phase = ST_LISTEN;
    end else if (w.mode == EV_APP_DATA && phase == ST_ESTABLISHED && !ack_wait) begin
      lim = app_room();
      n = (w.pay_len < lim) ? w.pay_len : lim;
      if (n == 0) begin
        err = 1'b1;
        phase = ST_CLOSED;
      end else begin
        queue_tx('0, snd_nxt, ack_sent, n);
        sent_len = 32'(n);
        rwnd -= 32'(n);
        ack_wait = 1'b1;
      end
    end else if (w.mode == EV_CLOSE && phase == ST_ESTABLISHED && !ack_wait) begin
      fin_peer();
      phase = ST_FIN_WAIT_1;
    end else if (w.mode == EV_SEGMENT && phase != ST_CLOSED) begin
      case (phase)
        ST_LISTEN: begin
          if (w.seg_flags == FL_SYN) begin
            absorb_ctrl(w.seg_seq, w.seg_ack, w.pay_len);
            snd_nxt = isn;
            queue_tx(FL_SYN | FL_ACK, isn, peer_seq + 32'd1, '0);
            ack_sent = peer_seq + 32'd1;
            sent_len = 32'd1;
            phase = ST_SYN_RCVD;
          end else err = 1'b1;
        end
        ST_SYN_OUT: begin
          if (w.seg_flags == (FL_SYN | FL_ACK)) begin
            absorb_ctrl(w.seg_seq, w.seg_ack, w.pay_len);
            phase = ST_ESTABLISHED;
            ack_peer();
          end else err = 1'b1;
        end
        ST_SYN_RCVD, ST_FIN_WAIT_1, ST_LAST_ACK: begin
          if (w.seg_flags == FL_ACK) begin
            absorb_ctrl(w.seg_seq, w.seg_ack, w.pay_len);
            grow_window(1'b0);
            phase = (phase == ST_SYN_RCVD) ? ST_ESTABLISHED :
                    (phase == ST_FIN_WAIT_1) ? ST_FIN_WAIT_2 : ST_CLOSED;
          end else err = 1'b1;
        end
        ST_FIN_WAIT_2: begin
          if (w.seg_flags == (FL_FIN | FL_ACK)) begin
            absorb_ctrl(w.seg_seq, w.seg_ack, w.pay_len);
            ack_peer();
            phase = ST_CLOSED;
          end else err = 1'b1;
        end
        ST_ESTABLISHED: begin
          if (ack_wait) begin
            if (w.seg_flags == FL_ACK) begin
              absorb_ctrl(w.seg_seq, w.seg_ack, w.pay_len);
              grow_window(1'b1);
              ack_wait = 1'b0;
            end else err = 1'b1;
          end else if (w.seg_flags == (FL_FIN | FL_ACK)) begin
            // peer FIN answered from the stored peer values, not this segment's
            ack_peer();
            fin_app = 1'b1;
            fin_peer();
            phase = ST_LAST_ACK;
          end else begin
            lim = app_room();
            peer_seq = w.seg_seq;
            peer_ack = w.seg_ack;
            peer_len = 32'((w.pay_len < lim) ? w.pay_len : lim);
            ack_peer();
          end
        end
        default: err = 1'b1;
      endcase
      if (err) begin
        phase = ST_CLOSED;
        ack_wait = 1'b0;
      end
    end

    total = (tx_n == 0) ? 1 : tx_n;
    for (int k = 0; k < total; k++) begin
      e = '0;
      if (k < tx_n) begin
        e.send_valid = 1'b1;
        e.out_flags  = tx_flags[k];
        e.out_seq    = tx_seq[k];
        e.out_ack    = tx_ack[k];
        e.out_window = adv_win;
        e.out_len    = tx_len[k];
      end
      e.conn_state = phase;
      e.app_limit  = app_room();
      e.fin_to_app = fin_app;
      e.error      = err;
      e.last       = (k == total - 1);
      segments_due.push_back(e);
    end
  endfunction

  function automatic void check_word(out_word_t got);
    out_word_t want;
    if (segments_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%t unexpected result word %h", $realtime, got);
      return;
    end
    want = segments_due.pop_front();
    words_checked++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%t result mismatch (got/exp):", $realtime);
        $display("  sv %b/%b fl %h/%h seq %h/%h ack %h/%h win %h/%h",
                 got.send_valid, want.send_valid, got.out_flags, want.out_flags,
                 got.out_seq, want.out_seq, got.out_ack, want.out_ack,
                 got.out_window, want.out_window);
        $display("  len %0d/%0d st %0d/%0d lim %0d/%0d fin %b/%b err %b/%b last %b/%b",
                 got.out_len, want.out_len, got.conn_state, want.conn_state,
                 got.app_limit, want.app_limit, got.fin_to_app, want.fin_to_app,
                 got.error, want.error, got.last, want.last);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      isn = 32'd1; adv_win = 16'd3072; mss = 11'd536;
      ssthresh = 16'd2144; win_cap = 16'd3072;
      phase = ST_CLOSED;
      restart_conn();
      segments_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ISN: isn      = cfg_data;
          REG_WIN: adv_win  = cfg_data[15:0];
          REG_MSS: mss      = cfg_data[10:0];
          REG_SST: ssthresh = cfg_data[15:0];
          REG_CAP: win_cap  = cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_word(out_word);
      if (in_valid && !in_stall) predict_event(in_word);
    end
    pending = segments_due.size();
  end

endmodule

[test/tcp_connection_engine_top_test.sv]
module tcp_connection_engine_top_test;
  import tce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_EVENTS = 1800;
  localparam int IDLE_LIMIT = 3000;  // cycles without any handshake
  localparam int DRAIN_WAIT = 40;    // covers the divide on a data ACK

  logic        clk, rst;
  logic        in_valid, in_stall;
  in_word_t    in_word;
  logic        out_valid, out_stall;
  out_word_t   out_word;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  int mismatches, pending, words_checked;
  int events_sent, settings_used, idle_cycles;
  bit calm;  // when set, neither side inserts gaps

  tcp_connection_engine_top i_dut (
    .clk, .rst, .in_valid, .in_stall, .in_word,
    .out_valid, .out_stall, .out_word,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  tcp_connection_engine_checker i_checker (
    .clk, .rst, .in_valid, .in_stall, .in_word,
    .out_valid, .out_stall, .out_word,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .pending, .words_checked
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: end the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pending);
        $display("tcp_connection_engine_top_test: FAIL");
        $finish;
      end
    end
  end

  // Receiver: draw a hold-off per word, then release the stall until a word moves.
  initial begin
    int g;
    bit go;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      g = calm ? 0 : $urandom_range(0, 18);
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        go = out_valid && !out_stall;
        @(posedge clk);
      end while (!go);
    end
  end

  // Drive one event word; keep valid high if the next word follows at once.
  task automatic send_word(in_word_t w);
    int  gap;
    bit  go;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(negedge clk);
      go = !in_stall;
      @(posedge clk);
    end while (!go);
  endtask

  function automatic in_word_t make_event(logic [2:0] m, logic [7:0] fl, logic [31:0] s,
                                          logic [31:0] a, logic [10:0] dl);
    in_word_t w;
    w.mode = m;
    w.seg_flags = fl;
    w.seg_seq = s;
    w.seg_ack = a;
    w.pay_len = dl;
    return w;
  endfunction

  function automatic logic [10:0] pick_len();
    case ($urandom_range(0, 7))
      0:       return 11'd0;
      1:       return 11'd1460;
      default: return 11'($urandom_range(1, 1460));
    endcase
  endfunction

  // Send an event; now and then slip a random word in front of it.
  task automatic step(event_t m, logic [7:0] fl, logic [10:0] dl);
    in_word_t junk;
    if ($urandom_range(0, 19) == 0) begin
      junk.mode      = 3'($urandom_range(0, 7));
      junk.seg_flags = 8'($urandom_range(0, 255));
      junk.seg_seq   = $urandom;
      junk.seg_ack   = $urandom;
      junk.pay_len   = pick_len();
      send_word(junk);
    end
    send_word(make_event(m, fl, $urandom, $urandom, dl));
    if (m <= EV_CLOSE) events_sent++;
  endtask

  // Drop valid, wait for every result, and let the engine settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write all five registers in one burst; valid stays high between them.
  task automatic program_regs(logic [31:0] isn_v, logic [15:0] win_v, logic [10:0] mss_v,
                              logic [15:0] sst_v, logic [15:0] cap_v);
    logic [31:0] vals [5];
    logic [2:0]  idx [5];
    bit          go;
    vals = '{isn_v, 32'(win_v), 32'(mss_v), 32'(sst_v), 32'(cap_v)};
    idx  = '{REG_ISN, REG_WIN, REG_MSS, REG_SST, REG_CAP};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do begin
        @(negedge clk);
        go = cfg_ready;
        @(posedge clk);
      end while (!go);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // One connection lifetime with random content; errors along the way are fine.
  task automatic session();
    if ($urandom_range(0, 1)) begin
      step(EV_OPEN_ACTIVE, '0, '0);
      step(EV_SEGMENT, FL_SYN | FL_ACK, pick_len());
    end else begin
      step(EV_OPEN_PASSIVE, '0, '0);
      step(EV_SEGMENT, FL_SYN, pick_len());
      step(EV_SEGMENT, FL_ACK, pick_len());
    end
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          // local data, stop-and-wait for its ACK
          step(EV_APP_DATA, '0, ($urandom_range(0, 15) == 0) ? 11'd0 : pick_len());
          step(EV_SEGMENT, ($urandom_range(0, 15) == 0) ? 8'($urandom) : FL_ACK,
               pick_len());
        end
        2: step(EV_SEGMENT, FL_ACK, pick_len());
        default: step(EV_SEGMENT, 8'($urandom_range(0, 255)) & ~FL_FIN, pick_len());
      endcase
    end
    if ($urandom_range(0, 1)) begin
      step(EV_CLOSE, '0, '0);
      step(EV_SEGMENT, FL_ACK, pick_len());
      step(EV_SEGMENT, FL_FIN | FL_ACK, pick_len());
    end else begin
      step(EV_SEGMENT, FL_FIN | FL_ACK, pick_len());
      step(EV_SEGMENT, FL_ACK, pick_len());
    end
  endtask

  initial begin
    int phase_no;
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ISN;
    cfg_data = '0;
    calm = 1'b0;
    events_sent = 0;
    settings_used = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: defaults, wrap of the peer sequence, clipping, errors, both closes.
    program_regs(32'd1, 16'd3072, 11'd536, 16'd2144, 16'd3072);
    send_word(make_event(EV_OPEN_ACTIVE, '0, '0, '0, '0));
    send_word(make_event(EV_APP_DATA, '0, '0, '0, 11'd100));  // ignored while SYN is out
    send_word(make_event(EV_SEGMENT, FL_SYN | FL_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd0));
    send_word(make_event(EV_APP_DATA, '0, '0, '0, 11'd1460));  // clipped to MSS
    send_word(make_event(EV_SEGMENT, FL_ACK, 32'h0, 32'h0, 11'd1460));
    send_word(make_event(EV_SEGMENT, 8'hFF, 32'h1234_5678, 32'h8765_4321, 11'd1460));
    send_word(make_event(EV_SEGMENT, FL_FIN | FL_ACK, 32'hAAAA_AAAA, 32'h5555_5555, 11'd7));
    send_word(make_event(EV_SEGMENT, FL_ACK, 32'h1, 32'h2, 11'd3));
    send_word(make_event(EV_SEGMENT, FL_ACK, 32'h1, 32'h2, 11'd3));  // segment in CLOSED
    send_word(make_event(3'd5, 8'hFF, '1, '1, 11'h7FF));
    send_word(make_event(3'd7, '0, '0, '0, '0));
    send_word(make_event(EV_OPEN_PASSIVE, '0, '0, '0, '0));
    send_word(make_event(EV_OPEN_ACTIVE, '0, '0, '0, '0));  // ignored outside CLOSED
    send_word(make_event(EV_SEGMENT, FL_SYN, 32'hFFFF_FFFF, 32'h0, 11'd1460));
    send_word(make_event(EV_SEGMENT, FL_ACK, 32'h10, 32'h20, 11'd0));
    send_word(make_event(EV_APP_DATA, '0, '0, '0, 11'd1));
    send_word(make_event(EV_SEGMENT, FL_SYN, 32'h10, 32'h20, 11'd0));  // wrong while awaiting ACK
    send_word(make_event(EV_OPEN_ACTIVE, '0, '0, '0, '0));
    send_word(make_event(EV_SEGMENT, FL_SYN | FL_ACK, 32'h100, 32'h200, 11'd20));
    send_word(make_event(EV_CLOSE, '0, '0, '0, '0));
    send_word(make_event(EV_SEGMENT, FL_ACK, 32'h121, 32'h201, 11'd0));
    send_word(make_event(EV_SEGMENT, FL_FIN | FL_ACK, 32'h121, 32'h201, 11'd0));
    send_word(make_event(EV_OPEN_ACTIVE, '0, '0, '0, '0));
    send_word(make_event(EV_SEGMENT, FL_SYN | FL_ACK, 32'h0, 32'h0, 11'd5));
    send_word(make_event(EV_APP_DATA, '0, '0, '0, 11'd0));  // empty app data
    events_sent += 23;

    // Random part: sessions under a rotation of register settings.
    phase_no = 0;
    while (events_sent < NUM_EVENTS + 25) begin
      if (events_sent >= 25 + phase_no * (NUM_EVENTS / 6)) begin
        drain();
        case (phase_no % 6)
          0: program_regs(32'd1, 16'd3072, 11'd536, 16'd2144, 16'd3072);
          1: program_regs(32'd0, 16'd0, 11'd1, 16'd1, 16'd1);
          2: program_regs(32'hFFFF_FFFF, 16'hFFFF, 11'd1460, 16'hFFFF, 16'hFFFF);
          3: program_regs($urandom, 16'($urandom), 11'($urandom_range(1, 1460)),
                          16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
          4: program_regs($urandom, 16'($urandom), 11'd64, 16'd200,
                          16'($urandom_range(1, 4000)));
          default: program_regs($urandom, 16'($urandom), 11'($urandom_range(1, 1460)),
                                16'($urandom_range(1, 3000)), 16'($urandom_range(1, 65535)));
        endcase
        phase_no++;
      end
      calm = ($urandom_range(0, 4) == 0);
      session();
    end

    drain();
    $display("covered %0d connection events under %0d register settings,", events_sent,
             settings_used);
    $display("with %0d result words compared and %0d mismatches", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("tcp_connection_engine_top_test: PASS");
    end else begin
      $display("tcp_connection_engine_top_test: FAIL");
    end
    $finish;
  end

endmodule
